@@ rtl/transient_averager_macros.svh @@
// Assertion helpers for the averager.
`ifndef TRANSIENT_AVERAGER_MACROS_SVH
`define TRANSIENT_AVERAGER_MACROS_SVH

// Clock and reset given explicitly.
`define TAVG_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Block clock and reset.
`define TAVG_ASSERT(label, prop, msg) \
   `TAVG_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/tavg_pkg.sv @@
`default_nettype none

package tavg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 18;
   localparam int IDX_W    = 12;
   localparam int MODE_W   = 2;
   localparam int NPTS_W   = 13;
   localparam int NTR_W    = 11;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam int OUT_MAX = 131071;

   localparam logic [MODE_W-1:0] MODE_ALL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ODD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EVEN  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CYCLE = 2'd3;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_POINTS = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   localparam logic [NPTS_W-1:0] POINTS_RST = 13'd1024;
   localparam logic [NTR_W-1:0]  COUNT_RST  = 11'd1;

endpackage

`default_nettype wire

@@ rtl/tavg_if.sv @@
`default_nettype none

interface tavg_req_if;
   import tavg_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface tavg_rsp_if;
   import tavg_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] avg_re;
   logic signed [OUT_W-1:0] avg_im;
   logic [IDX_W-1:0]        point_index;
   logic                    last_point;
   logic                    zero_divisor;

   modport source (output valid, output avg_re, output avg_im, output point_index,
                   output last_point, output zero_divisor, input ready);
   modport sink   (input valid, input avg_re, input avg_im, input point_index,
                   input last_point, input zero_divisor, output ready);
endinterface

`default_nettype wire

@@ rtl/transient_averager.sv @@
`default_nettype none
// Channel   Dir  Handshake        Item
// req_if    in   valid/ready      sample_re, sample_im
// rsp_if    out  valid/ready      avg_re, avg_im, point_index, last_point, zero_divisor
// csr       in   APB psel/penable averaging_mode, points_per_transient, transient_count
//
// Outside the last transient an item is read from and then added/written back to
// the accumulator memory. In the last transient with a nonzero divisor the shared
// restoring divider runs real then imaginary part, one quotient bit a cycle. Reset is
// synchronous; the accumulator memory is not cleared, the first transient overwrites
// it. A result waits in the output register; a stalled rsp_if holds the sequencer in
// its output state.

`include "transient_averager_macros.svh"

module transient_averager #(
   parameter int MAX_POINTS     = 4096,
   parameter int MAX_TRANSIENTS = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   tavg_req_if.sink                          req_if,
   tavg_rsp_if.source                        rsp_if,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [tavg_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [tavg_pkg::DATA_W-1:0]  pwdata,
   output logic [tavg_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import tavg_pkg::*;

   localparam int PW      = $clog2(MAX_POINTS);
   localparam int MAXT_EF = (MAX_TRANSIENTS > 2047) ? 2047 : MAX_TRANSIENTS;
   localparam int ACC_W   = 17 + $clog2(MAXT_EF);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_ADD    = 6'b000100,
      ST_DIV_RE = 6'b001000,
      ST_DIV_IM = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [MODE_W-1:0]       mode_ff;
   logic [NPTS_W-1:0]       pts_ff;
   logic [NTR_W-1:0]        cnt_ff;
   logic [PW-1:0]           pt_cnt_ff, pt_cnt_in;
   logic [NTR_W-1:0]        tr_cnt_ff, tr_cnt_in;

   logic signed [SAMPLE_W-1:0] smp_re_ff, smp_im_ff;
   logic [2*ACC_W-1:0]         acc_mem [MAX_POINTS];
   logic [2*ACC_W-1:0]         acc_rd_ff;
   logic signed [ACC_W-1:0]    sum_im_ff;
   logic signed [ACC_W-1:0]    sum_re_in, sum_im_in;
   logic signed [ACC_W-1:0]    base_re, base_im, ext_re, ext_im;

   logic [PW-1:0]              idx_ff;
   logic                       last_pt_ff, zero_ff;
   logic signed [OUT_W-1:0]    q_re_ff, q_re_in, q_im_ff, q_im_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    avg_re_ff, avg_im_ff;
   logic [IDX_W-1:0]           index_ff;
   logic                       last_ff, zdiv_ff;

   logic                       cfg_we, cfg_restart;
   logic [1:0]                 cfg_idx;
   logic [PW-1:0]              last_idx;
   logic [NTR_W-1:0]           cnt_eff, last_tr_idx, divisor;
   logic                       last_pt, last_tr, zero_div, odd;
   logic                       req_take, out_load;
   logic                       do_add, do_sub;

   logic                       div_start, div_done;
   logic signed [ACC_W-1:0]    div_dividend;
   logic signed [OUT_W-1:0]    div_quo;

   // configuration port
   assign pready      = 1'b1;
   assign cfg_idx     = paddr[3:2];
   assign cfg_we      = psel && penable && pwrite;
   assign cfg_restart = cfg_we && (cfg_idx == REG_MODE || cfg_idx == REG_POINTS ||
                                   cfg_idx == REG_COUNT);

   always_comb begin
      unique case (cfg_idx)
         REG_MODE:   prdata = DATA_W'(mode_ff);
         REG_POINTS: prdata = DATA_W'(pts_ff);
         REG_COUNT:  prdata = DATA_W'(cnt_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ALL;
         pts_ff  <= POINTS_RST;
         cnt_ff  <= COUNT_RST;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_MODE:   mode_ff <= pwdata[MODE_W-1:0];
            REG_POINTS: pts_ff  <= pwdata[NPTS_W-1:0];
            REG_COUNT:  cnt_ff  <= pwdata[NTR_W-1:0];
            default:    ;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      if (pts_ff == '0) begin
         last_idx = '0;
      end else if (32'(pts_ff) > 32'(MAX_POINTS)) begin
         last_idx = PW'(MAX_POINTS - 1);
      end else begin
         last_idx = PW'(pts_ff - NPTS_W'(1));
      end
   end

   assign cnt_eff     = (32'(cnt_ff) > 32'(MAX_TRANSIENTS)) ? NTR_W'(MAX_TRANSIENTS) : cnt_ff;
   assign last_tr_idx = (cnt_eff == '0) ? '0 : cnt_eff - NTR_W'(1);
   assign divisor     = (mode_ff == MODE_ODD || mode_ff == MODE_EVEN) ? (cnt_eff >> 1) : cnt_eff;
   assign zero_div    = (divisor == '0);
   assign last_pt     = (pt_cnt_ff == last_idx);
   assign last_tr     = (tr_cnt_ff == last_tr_idx);
   assign odd         = ~tr_cnt_ff[0];

   always_comb begin
      do_add = 1'b0;
      do_sub = 1'b0;
      case (mode_ff)
         MODE_ALL:   do_add = 1'b1;
         MODE_ODD:   do_add = odd;
         MODE_EVEN:  do_add = ~odd;
         default: begin
            do_add = odd;
            do_sub = ~odd;
         end
      endcase
   end

   // accumulate
   assign base_re = (tr_cnt_ff == '0) ? '0 : $signed(acc_rd_ff[2*ACC_W-1 -: ACC_W]);
   assign base_im = (tr_cnt_ff == '0) ? '0 : $signed(acc_rd_ff[ACC_W-1:0]);
   assign ext_re  = ACC_W'(smp_re_ff);
   assign ext_im  = ACC_W'(smp_im_ff);

   always_comb begin
      sum_re_in = base_re;
      sum_im_in = base_im;
      if (do_add) begin
         sum_re_in = base_re + ext_re;
         sum_im_in = base_im + ext_im;
      end else if (do_sub) begin
         sum_re_in = base_re - ext_re;
         sum_im_in = base_im - ext_im;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         acc_rd_ff <= acc_mem[pt_cnt_ff];
      end
      if (state_ff == ST_ADD) begin
         acc_mem[pt_cnt_ff] <= {sum_re_in, sum_im_in};
      end
   end

   // sequencer
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);
   assign div_start    = ((state_ff == ST_ADD) && last_tr && !zero_div) ||
                         ((state_ff == ST_DIV_RE) && div_done);
   assign div_dividend = (state_ff == ST_ADD) ? sum_re_in : sum_im_ff;

   always_comb begin
      state_in = state_ff;
      q_re_in  = q_re_ff;
      q_im_in  = q_im_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (!last_tr) begin
               state_in = ST_IDLE;
            end else if (zero_div) begin
               q_re_in  = '0;
               q_im_in  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV_RE;
            end
         end
         ST_DIV_RE: begin
            if (div_done) begin
               q_re_in  = div_quo;
               state_in = ST_DIV_IM;
            end
         end
         ST_DIV_IM: begin
            if (div_done) begin
               q_im_in  = div_quo;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pt_cnt_in = pt_cnt_ff;
      tr_cnt_in = tr_cnt_ff;
      if (cfg_restart) begin
         pt_cnt_in = '0;
         tr_cnt_in = '0;
      end else if (state_ff == ST_ADD) begin
         if (last_pt) begin
            pt_cnt_in = '0;
            tr_cnt_in = last_tr ? '0 : tr_cnt_ff + NTR_W'(1);
         end else begin
            pt_cnt_in = pt_cnt_ff + PW'(1);
         end
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pt_cnt_ff    <= '0;
         tr_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pt_cnt_ff    <= pt_cnt_in;
         tr_cnt_ff    <= tr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         smp_re_ff <= req_if.sample_re;
         smp_im_ff <= req_if.sample_im;
      end
      if (state_ff == ST_ADD) begin
         sum_im_ff  <= sum_im_in;
         idx_ff     <= pt_cnt_ff;
         last_pt_ff <= last_pt;
         zero_ff    <= zero_div;
      end
      q_re_ff <= q_re_in;
      q_im_ff <= q_im_in;
      if (out_load) begin
         avg_re_ff <= q_re_ff;
         avg_im_ff <= q_im_ff;
         index_ff  <= IDX_W'(idx_ff);
         last_ff   <= last_pt_ff;
         zdiv_ff   <= zero_ff;
      end
   end

   tavg_div #(
      .ACC_WIDTH (ACC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.avg_re       = avg_re_ff;
   assign rsp_if.avg_im       = avg_im_ff;
   assign rsp_if.point_index  = index_ff;
   assign rsp_if.last_point   = last_ff;
   assign rsp_if.zero_divisor = zdiv_ff;

   `TAVG_ASSERT(a_pt_range, pt_cnt_ff <= last_idx, "point counter beyond last point")
   `TAVG_ASSERT(a_zero_out, rsp_if.valid && rsp_if.zero_divisor |-> rsp_if.avg_re == '0 && rsp_if.avg_im == '0, "zero divisor result not forced to zero")
   `TAVG_ASSERT(a_div_busy, div_done |-> state_ff == ST_DIV_RE || state_ff == ST_DIV_IM, "divider finished outside a divide state")
   `TAVG_ASSERT(a_one_item, req_take |=> !req_if.ready, "item taken while previous one in work")

endmodule

`default_nettype wire

@@ rtl/tavg_div.sv @@
`default_nettype none

module tavg_div #(
   parameter int ACC_WIDTH = 27
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [ACC_WIDTH-1:0]         dividend,
   input  wire logic [tavg_pkg::NTR_W-1:0]          divisor,
   output logic                                     done,
   output logic signed [tavg_pkg::OUT_W-1:0]        quotient
);
   import tavg_pkg::*;

   localparam int STEP_W = $clog2(ACC_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [ACC_WIDTH-1:0] quo_ff, quo_in;
   logic [NTR_W-1:0]     rem_ff, rem_in;
   logic [NTR_W-1:0]     div_ff, div_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [NTR_W:0]       trial;
   logic                 fits;
   logic [ACC_WIDTH-1:0] mag;
   logic                 sat;

   assign trial = {rem_ff, quo_ff[ACC_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign mag   = dividend[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - dividend) : dividend;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[ACC_WIDTH-1];
         quo_in  = mag;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(ACC_WIDTH - 1);
      end else if (busy_ff) begin
         rem_in  = fits ? NTR_W'(trial - {1'b0, div_ff}) : trial[NTR_W-1:0];
         quo_in  = {quo_ff[ACC_WIDTH-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   // saturate magnitude to the signed output range
   assign sat = neg_ff ? (quo_ff > ACC_WIDTH'(OUT_MAX + 1)) : (quo_ff > ACC_WIDTH'(OUT_MAX));

   always_comb begin
      if (sat) begin
         quotient = neg_ff ? OUT_W'(-OUT_MAX - 1) : OUT_W'(OUT_MAX);
      end else if (neg_ff) begin
         quotient = OUT_W'(0) - quo_ff[OUT_W-1:0];
      end else begin
         quotient = quo_ff[OUT_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
   import tavg_pkg::*;

   localparam int MAX_PTS      = 4096;
   localparam int MAX_TR       = 1024;
   localparam int RAND_ITEMS   = 1900;
   localparam int DRAIN_CYCLES = 250;

   typedef struct packed {
      logic signed [OUT_W-1:0] avg_re;
      logic signed [OUT_W-1:0] avg_im;
      logic [IDX_W-1:0]        point_index;
      logic                    last_point;
      logic                    zero_divisor;
   } avg_t;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_e;

   typedef struct packed {
      row_kind_e                  kind;
      logic [1:0]                 reg_idx;
      logic [31:0]                value;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       typed;
      avg_t                       want;
   } row_t;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   tavg_req_if req_if();
   tavg_rsp_if rsp_if();

   transient_averager DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // averager state
   longint            sum_re [MAX_PTS];
   longint            sum_im [MAX_PTS];
   int unsigned       pt_ctr;
   int unsigned       tr_ctr;
   logic [MODE_W-1:0] cfg_mode;
   logic [NPTS_W-1:0] cfg_points;
   logic [NTR_W-1:0]  cfg_count;

   avg_t pending_avgs [$];
   row_t plan [$];

   int  mismatches;
   int  items_in;
   int  results_seen;
   int  csr_writes;
   bit  tx_idle;
   bit  rx_idle;

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic logic [OUT_W-1:0] sat18(longint q);
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end
      if (q < -OUT_MAX - 1) begin
         q = -OUT_MAX - 1;
      end
      return q[OUT_W-1:0];
   endfunction

   function automatic int unsigned eff_points();
      if (cfg_points < 1) begin
         return 1;
      end
      return (cfg_points > MAX_PTS) ? MAX_PTS : cfg_points;
   endfunction

   function automatic int unsigned eff_runs();
      int unsigned cnt;
      cnt = (cfg_count > MAX_TR) ? MAX_TR : cfg_count;
      return (cnt < 1) ? 1 : cnt;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [31:0] val);
      case (idx)
         REG_MODE: begin
            cfg_mode = val[MODE_W-1:0];
         end
         REG_POINTS: begin
            cfg_points = val[NPTS_W-1:0];
         end
         REG_COUNT: begin
            cfg_count = val[NTR_W-1:0];
         end
         default: begin
         end
      endcase
      pt_ctr = 0;
      tr_ctr = 0;
   endfunction

   // accumulate one sample; returns 1 when an average comes out
   function automatic bit average_sample(input logic signed [SAMPLE_W-1:0] re,
                                         input logic signed [SAMPLE_W-1:0] im,
                                         output avg_t r);
      int unsigned pts;
      int unsigned cnt;
      int unsigned runs;
      int unsigned divisor;
      int unsigned p;
      bit          odd;
      bit          last_tr;
      bit          last_pt;
      longint      sgn;
      longint      qr;
      longint      qi;
      pts     = eff_points();
      cnt     = (cfg_count > MAX_TR) ? MAX_TR : cfg_count;
      runs    = eff_runs();
      divisor = (cfg_mode == MODE_ODD || cfg_mode == MODE_EVEN) ? cnt / 2 : cnt;
      if (pt_ctr >= pts) begin
         pt_ctr = 0;
      end
      if (tr_ctr >= runs) begin
         tr_ctr = 0;
      end
      p   = pt_ctr;
      odd = (tr_ctr % 2) == 0;
      case (cfg_mode)
         MODE_ALL: begin
            sgn = 1;
         end
         MODE_ODD: begin
            sgn = odd ? 1 : 0;
         end
         MODE_EVEN: begin
            sgn = odd ? 0 : 1;
         end
         default: begin
            sgn = odd ? 1 : -1;
         end
      endcase
      if (tr_ctr == 0) begin
         sum_re[p] = 0;
         sum_im[p] = 0;
      end
      sum_re[p] += sgn * longint'(re);
      sum_im[p] += sgn * longint'(im);
      last_tr = (tr_ctr == runs - 1);
      last_pt = (p == pts - 1);
      r = '0;
      if (last_tr) begin
         qr = 0;
         qi = 0;
         if (divisor != 0) begin
            qr = sum_re[p] / longint'(divisor);
            qi = sum_im[p] / longint'(divisor);
         end
         r.avg_re       = sat18(qr);
         r.avg_im       = sat18(qi);
         r.point_index  = p[IDX_W-1:0];
         r.last_point   = last_pt;
         r.zero_divisor = (divisor == 0);
      end
      if (last_pt) begin
         pt_ctr = 0;
         tr_ctr = last_tr ? 0 : tr_ctr + 1;
      end else begin
         pt_ctr = p + 1;
      end
      return last_tr;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int          r;
      logic [31:0] w;
      r = $urandom_range(0, 99);
      w = $urandom;
      if (r < 70) begin
         return w[SAMPLE_W-1:0];
      end else if (r < 85) begin
         case (w[1:0])
            2'd0: return 16'sd32767;
            2'd1: return -16'sd32768;
            2'd2: return 16'sd0;
            default: return -16'sd1;
         endcase
      end
      return $urandom_range(0, 6) - 3;
   endfunction

   function automatic void add_csr(logic [1:0] idx, logic [31:0] val);
      row_t row;
      row = '0;
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.value   = val;
      plan.push_back(row);
   endfunction

   function automatic void add_item(int re, int im);
      row_t row;
      row = '0;
      row.kind = ROW_ITEM;
      row.re   = re;
      row.im   = im;
      plan.push_back(row);
   endfunction

   function automatic void add_known(int re, int im, int wre, int wim, int idx,
                                     bit last, bit zd);
      row_t row;
      row = '0;
      row.kind              = ROW_ITEM;
      row.re                = re;
      row.im                = im;
      row.typed             = 1'b1;
      row.want.avg_re       = wre;
      row.want.avg_im       = wim;
      row.want.point_index  = idx;
      row.want.last_point   = last;
      row.want.zero_divisor = zd;
      plan.push_back(row);
   endfunction

   task automatic send_sample(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im,
                              bit typed, avg_t want);
      int   gap;
      avg_t pred;
      bit   has;
      gap = tx_idle ? gap_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_re <= re;
      req_if.sample_im <= im;
      do @(posedge clock); while (!req_if.ready);
      has = average_sample(re, im, pred);
      if (has) begin
         pending_avgs.push_back(typed ? want : pred);
      end
      items_in++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_csr(idx, val);
      csr_writes++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== val) begin
         note_mismatch($sformatf("readback reg %0d: want %0h got %0h", idx, val, prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      avg_t want;
      avg_t got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.avg_re       = rsp_if.avg_re;
         got.avg_im       = rsp_if.avg_im;
         got.point_index  = rsp_if.point_index;
         got.last_point   = rsp_if.last_point;
         got.zero_divisor = rsp_if.zero_divisor;
         results_seen++;
         if (pending_avgs.size() == 0) begin
            note_mismatch($sformatf("unexpected average: re %0d im %0d idx %0d",
                                    got.avg_re, got.avg_im, got.point_index));
         end else begin
            want = pending_avgs.pop_front();
            if (got.avg_re !== want.avg_re || got.avg_im !== want.avg_im ||
                got.point_index !== want.point_index ||
                got.last_point !== want.last_point ||
                got.zero_divisor !== want.zero_divisor) begin
               note_mismatch($sformatf(
                  "average: want re %0d im %0d idx %0d last %0b zd %0b, got re %0d im %0d idx %0d last %0b zd %0b",
                  want.avg_re, want.avg_im, want.point_index, want.last_point,
                  want.zero_divisor, got.avg_re, got.avg_im, got.point_index,
                  got.last_point, got.zero_divisor));
            end
         end
      end
   end

   initial begin
      int run;
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         stall = rx_idle ? gap_len() : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      int                 phase;
      int                 rand_items;
      int                 r;
      int                 n;
      int unsigned        per;
      bit                 wrote;
      logic [MODE_W-1:0]  new_mode;
      logic [NPTS_W-1:0]  new_points;
      logic [NTR_W-1:0]   new_count;
      row_t               row;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample_re = '0;
      req_if.sample_im = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      mismatches       = 0;
      items_in         = 0;
      results_seen     = 0;
      csr_writes       = 0;
      tx_idle          = 1'b1;
      rx_idle          = 1'b1;
      cfg_mode         = MODE_ALL;
      cfg_points       = POINTS_RST;
      cfg_count        = COUNT_RST;
      pt_ctr           = 0;
      tr_ctr           = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      add_known(32767, -32768, 32767, -32768, 0, 1'b0, 1'b0);
      add_known(-32768, 32767, -32768, 32767, 1, 1'b0, 1'b0);
      add_csr(REG_POINTS, 0);
      add_known(1, -1, 1, -1, 0, 1'b1, 1'b0);
      add_csr(REG_COUNT, 0);
      add_known(12345, -321, 0, 0, 0, 1'b1, 1'b1);
      add_csr(REG_MODE, MODE_ODD);
      add_known(-1, 1, 0, 0, 0, 1'b1, 1'b1);
      add_csr(REG_COUNT, 1);
      add_known(77, -77, 0, 0, 0, 1'b1, 1'b1);
      add_csr(REG_MODE, MODE_EVEN);
      add_csr(REG_COUNT, 2);
      add_item(100, 200);
      add_known(-7, 9, -7, 9, 0, 1'b1, 1'b0);
      add_csr(REG_MODE, MODE_CYCLE);
      add_csr(REG_POINTS, 2);
      add_item(1000, -1000);
      add_item(32767, -32768);
      add_item(-32768, 32767);
      add_item(3, -3);
      add_csr(REG_MODE, MODE_ALL);
      add_csr(REG_POINTS, 1);
      add_csr(REG_COUNT, 3);
      add_item(32767, -32768);
      add_item(32767, -32768);
      add_known(32767, -32768, 32767, -32768, 0, 1'b1, 1'b0);
      add_csr(REG_COUNT, 2);
      add_item(-3, 3);
      add_known(0, 0, -1, 1, 0, 1'b1, 1'b0);
      add_item(5, 5);
      add_csr(REG_COUNT, 2);
      add_item(8, -8);
      add_item(2, 2);
      add_csr(REG_POINTS, 4096);
      add_csr(REG_COUNT, 1024);
      add_item(-32768, -32768);
      add_item(32767, 32767);
      add_item(0, -1);
      add_csr(REG_POINTS, 8191);
      add_item(-2, 2);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            csr_write(row.reg_idx, row.value);
         end else begin
            send_sample(row.re, row.im, row.typed, row.want);
         end
      end

      // random acquisitions
      phase      = 0;
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         phase++;
         new_mode = $urandom_range(0, 3);
         if (phase == 3) begin
            new_points = 1;
            new_count  = 2047;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               new_points = $urandom_range(1, 8);
            end else if (r < 88) begin
               new_points = $urandom_range(9, 40);
            end else if (r < 94) begin
               new_points = 0;
            end else if (r < 97) begin
               new_points = 4096;
            end else begin
               new_points = $urandom_range(4097, 8191);
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
               new_count = $urandom_range(0, 4);
            end else if (r < 88) begin
               new_count = $urandom_range(5, 12);
            end else if (r < 96) begin
               new_count = $urandom_range(13, 40);
            end else begin
               new_count = $urandom_range(1025, 2047);
            end
         end

         wait_idle();
         tx_idle = ($urandom_range(0, 4) != 0);
         rx_idle = ($urandom_range(0, 4) != 0);
         wrote   = 1'b0;
         if (phase == 1 || new_mode != cfg_mode || $urandom_range(0, 2) == 0) begin
            csr_write(REG_MODE, new_mode);
            wrote = 1'b1;
         end
         if (phase == 1 || new_points != cfg_points || $urandom_range(0, 2) == 0) begin
            csr_write(REG_POINTS, new_points);
            wrote = 1'b1;
         end
         if (phase == 1 || new_count != cfg_count || $urandom_range(0, 2) == 0) begin
            csr_write(REG_COUNT, new_count);
            wrote = 1'b1;
         end
         if (!wrote) begin
            csr_write(REG_MODE, new_mode);
         end

         per = eff_points() * eff_runs();
         if (phase == 3) begin
            n = per;
         end else if (per <= 300) begin
            n = per * $urandom_range(1, 2);
            if (per > 1 && $urandom_range(0, 2) == 0) begin
               n += $urandom_range(1, per - 1);
            end
         end else begin
            n = $urandom_range(20, 80);
         end

         repeat (n) begin
            send_sample(pick_sample(), pick_sample(), 1'b0, '0);
            rand_items++;
         end
      end

      wait_idle();
      $display("summary: %0d samples in, %0d averages checked, %0d register writes",
               items_in, results_seen, csr_writes);
      $display("summary: all four modes, point counts 0..8191, transient counts 0..2047");
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
